[hw/rtl/i2cms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// shared types and constants of the i2c master byte sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int unsigned TPP_W   = 16;
    localparam int unsigned PHASE_W = 5;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 16;

    // command codes
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // final phase index of each command
    localparam logic [PHASE_W-1:0] LAST_START = 5'd2;
    localparam logic [PHASE_W-1:0] LAST_STOP  = 5'd1;
    localparam logic [PHASE_W-1:0] LAST_WRITE = 5'd26;
    localparam logic [PHASE_W-1:0] LAST_READ  = 5'd19;

    localparam logic [2:0] MSB_INDEX = 3'd7;

    typedef struct packed {
        logic              sda_level;
        logic              send_nack;
        logic [BYTE_W-1:0] tx_byte;
        logic [1:0]        action;
        logic              cmd_valid;
    } in_item_t;

    typedef struct packed {
        logic              ack_status;
        logic [BYTE_W-1:0] rx_byte;
        logic              done_res;
        logic              busy_res;
        logic              sda_drive;
        logic              scl;
    } out_item_t;

endpackage

[hw/rtl/i2cms_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_in_stage
// input register: captures one tick beat and holds it until the core takes it
// ----------------------------------------------------------------------------
module i2cms_in_stage
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [i2cms_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                take,
    output logic                                item_valid,
    output i2cms_pkg::in_item_t                 item
);

    logic                valid_reg;
    logic                valid_next;
    i2cms_pkg::in_item_t item_reg;
    logic                load;

    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= i2cms_pkg::in_item_t'(s_tdata[$bits(i2cms_pkg::in_item_t)-1:0]);
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hw/rtl/i2cms_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_seq
// bus phase sequencer state and result register
// ----------------------------------------------------------------------------
module i2cms_seq
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [i2cms_pkg::TPP_W-1:0]         cfg_wr_data,
    input  logic                                item_valid,
    input  i2cms_pkg::in_item_t                 item,
    output logic                                take,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output i2cms_pkg::out_item_t                result
);

    typedef struct packed {
        logic scl;
        logic sda;
        logic sample;
    } phase_t;

    logic [i2cms_pkg::TPP_W-1:0]   tpp_reg;
    logic                          scl_reg,   scl_next;
    logic                          sda_reg,   sda_next;
    logic                          busy_reg,  busy_next;
    logic [1:0]                    act_reg,   act_next;
    logic [i2cms_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [i2cms_pkg::TPP_W-1:0]   tick_reg,  tick_next;
    logic [i2cms_pkg::BYTE_W-1:0]  shift_reg, shift_next;
    logic                          nack_reg,  nack_next;
    logic [i2cms_pkg::BYTE_W-1:0]  rx_reg,    rx_next;
    logic                          ack_reg,   ack_next;
    logic                          out_valid_reg;
    i2cms_pkg::out_item_t          result_reg, result_next;

    logic                          fire;
    logic [i2cms_pkg::TPP_W:0]     tick_inc;
    logic [i2cms_pkg::TPP_W:0]     tpp_eff;
    logic                          phase_end;
    logic [i2cms_pkg::PHASE_W-1:0] last_p;
    phase_t                        ph;

    // scl/sda levels of a phase and whether sda is sampled at its end
    function automatic phase_t phase_levels(
        input logic [1:0]                    act,
        input logic [i2cms_pkg::PHASE_W-1:0] p,
        input logic [i2cms_pkg::BYTE_W-1:0]  sb,
        input logic                          nk
    );
        phase_t      r;
        logic [4:0]  n;
        logic [8:0]  prod;
        logic [2:0]  k;
        logic [4:0]  sub;
        n    = p - 5'd1;
        // n / 3 for n below 24, via reciprocal multiply
        prod = 9'(n) * 9'd11;
        k    = prod[7:5];
        sub  = n - 5'(k) * 5'd3;
        r    = '{scl: 1'b0, sda: 1'b1, sample: 1'b0};
        case (act)
            i2cms_pkg::ACT_START:
            begin
                r.scl = (p < 5'd2);
                r.sda = (p == 5'd0);
            end
            i2cms_pkg::ACT_STOP:
            begin
                r.scl = 1'b1;
                r.sda = (p != 5'd0);
            end
            i2cms_pkg::ACT_WRITE:
            begin
                if (p == 5'd0)
                begin
                    r.sda = 1'b0;
                end
                else if (p <= 5'd24)
                begin
                    r.sda = sb[i2cms_pkg::MSB_INDEX - k];
                    r.scl = (sub == 5'd1);
                end
                else
                begin
                    r.scl    = (p == 5'd25);
                    r.sample = (p == 5'd25);
                end
            end
            i2cms_pkg::ACT_READ:
            begin
                if (p < 5'd16)
                begin
                    r.scl    = !p[0];
                    r.sample = !p[0];
                end
                else
                begin
                    r.sda = (p == 5'd16) ? 1'b0 : nk;
                    r.scl = (p == 5'd18);
                end
            end
            default:
            begin
                r = '{scl: 1'b0, sda: 1'b1, sample: 1'b0};
            end
        endcase
        return r;
    endfunction

    assign take = !out_valid_reg || m_tready;
    assign fire = item_valid && take;

    always_comb
    begin
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        busy_next  = busy_reg;
        act_next   = act_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        nack_next  = nack_reg;
        rx_next    = rx_reg;
        ack_next   = ack_reg;

        // new command on an idle tick
        if (!busy_reg && item.cmd_valid)
        begin
            busy_next  = 1'b1;
            act_next   = item.action;
            phase_next = '0;
            tick_next  = '0;
            nack_next  = item.send_nack;
            shift_next = (item.action == i2cms_pkg::ACT_WRITE) ? item.tx_byte : '0;
        end

        ph        = phase_levels(act_next, phase_next, shift_next, nack_next);
        tick_inc  = {1'b0, tick_next} + 17'd1;
        tpp_eff   = (tpp_reg == '0) ? 17'd1 : {1'b0, tpp_reg};
        phase_end = (tick_inc >= tpp_eff);

        case (act_next)
            i2cms_pkg::ACT_START: last_p = i2cms_pkg::LAST_START;
            i2cms_pkg::ACT_STOP:  last_p = i2cms_pkg::LAST_STOP;
            i2cms_pkg::ACT_WRITE: last_p = i2cms_pkg::LAST_WRITE;
            i2cms_pkg::ACT_READ:  last_p = i2cms_pkg::LAST_READ;
            default:              last_p = i2cms_pkg::LAST_START;
        endcase

        result_next.busy_res = busy_next;
        result_next.done_res = 1'b0;

        if (busy_next)
        begin
            scl_next = ph.scl;
            sda_next = ph.sda;
            if (phase_end)
            begin
                if (ph.sample)
                begin
                    if (act_next == i2cms_pkg::ACT_WRITE)
                    begin
                        ack_next = item.sda_level;
                    end
                    else
                    begin
                        shift_next = {shift_next[i2cms_pkg::BYTE_W-2:0], item.sda_level};
                    end
                end
                if (phase_next >= last_p)
                begin
                    if (act_next == i2cms_pkg::ACT_READ)
                    begin
                        rx_next = shift_next;
                    end
                    busy_next            = 1'b0;
                    result_next.done_res = 1'b1;
                    phase_next           = '0;
                end
                else
                begin
                    phase_next = phase_next + 5'd1;
                end
                tick_next = '0;
            end
            else
            begin
                tick_next = tick_inc[i2cms_pkg::TPP_W-1:0];
            end
        end

        result_next.scl        = scl_next;
        result_next.sda_drive  = sda_next;
        result_next.rx_byte    = rx_next;
        result_next.ack_status = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpp_reg       <= 16'd1;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            busy_reg      <= 1'b0;
            act_reg       <= i2cms_pkg::ACT_START;
            phase_reg     <= '0;
            tick_reg      <= '0;
            shift_reg     <= '0;
            nack_reg      <= 1'b0;
            rx_reg        <= '0;
            ack_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                tpp_reg <= cfg_wr_data;
            end
            if (fire)
            begin
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                busy_reg  <= busy_next;
                act_reg   <= act_next;
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                shift_reg <= shift_next;
                nack_reg  <= nack_next;
                rx_reg    <= rx_next;
                ack_reg   <= ack_next;
            end
            if (take)
            begin
                out_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign result   = result_reg;

endmodule

[hw/rtl/i2c_master_byte_sequencer_core.sv]
`timescale 1ns / 1ps
// a tick beat accepted into the input register is worked into the result register when the
//   sequencer takes it, and its result beat is then offered from the result register
// throughput: one tick beat per clock cycle while m_tready is high; a stalled result beat
//   holds the sequencer, the input register then fills and s_tready drops
// reset: rst_n asynchronous active low; bus lines released high, idle, one tick
//   per phase
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_core
// i2c master line sequencer: start, stop, write byte with ack check and read
// byte with ack/nack answer, one bus tick per stream beat
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    // phase length register
    input  logic                                cfg_wr_en,
    input  logic [i2cms_pkg::TPP_W-1:0]         cfg_wr_data,

    // tick beats in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cmd_valid[0], action[2:1], tx_byte[10:3], send_nack[11], sda_level[12], zero[15:13]
    input  logic [i2cms_pkg::S_TDATA_W-1:0]     s_tdata,

    // result beats out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // scl[0], sda_drive[1], busy_res[2], done_res[3], rx_byte[11:4], ack_status[12],
    // zero[15:13]
    output logic [i2cms_pkg::M_TDATA_W-1:0]     m_tdata
);

    // handoff between input register and sequencer
    logic                 item_valid;
    i2cms_pkg::in_item_t  item;
    logic                 take;
    i2cms_pkg::out_item_t result;

    // input register stage: holds a beat while the result side is stalled
    i2cms_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // sequencer: phase counter, tick counter, shift register and the result
    // register, all advanced together once per accepted tick
    i2cms_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .take        (take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .result      (result)
    );

    // pad the result beat to whole bytes
    assign m_tdata = {{(i2cms_pkg::M_TDATA_W - $bits(i2cms_pkg::out_item_t)){1'b0}}, result};

endmodule
